/* hw/rtl/skdr_pkg.sv */
// Shared constants, types and tables for the skid-steer dead reckoning unit.
`timescale 1ns / 1ps
package skdr_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int CORD_IDX_W   = $clog2(ATAN_ENTRIES);
	localparam int CORD_W       = 34;
	localparam int COUNT_W      = 32;
	localparam int YAW_W        = 16;
	localparam int ELAPSED_W    = 20;
	localparam int SUM_W        = COUNT_W + 2;
	localparam int DIST_W       = 48;
	localparam int DIST_FRAC    = 18;
	localparam int TRIG_FRAC    = 30;
	localparam int MA_W         = 36;
	localparam int MB_W         = 21;
	localparam int PROD_W       = MA_W + MB_W;
	localparam int ACC_W        = 82;
	localparam int NUMS_W       = 55;
	localparam int NUM_W        = NUMS_W - 1;
	localparam int CNT_W        = $clog2(NUM_W);
	localparam int DTH_W        = YAW_W + 1;
	localparam logic [31:0] MPC_RESET = 32'd272375;
	localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [MB_W-1:0] VEL_SCALE = 21'sd1000000;

	typedef enum logic [3:0] {
		MAC_SUM_LO,
		MAC_SUM_HI,
		MAC_CX0,
		MAC_CX1,
		MAC_CX2,
		MAC_SY0,
		MAC_SY1,
		MAC_SY2,
		MAC_LIN,
		MAC_ANG
	} mac_op_t;

	typedef struct packed {
		logic                  capture;
		logic                  sum;
		logic                  mac_en;
		logic                  mac_first;
		mac_op_t               mac_op;
		logic                  cord_step;
		logic [CORD_IDX_W-1:0] cord_idx;
		logic                  dist_latch;
		logic                  px_latch;
		logic                  py_latch;
		logic                  numl_latch;
		logic                  div_init;
		logic                  div_step;
		logic                  load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic time_zero;
	} dp_status_t;

	function automatic logic signed [CORD_W-1:0] atan_entry(input logic [CORD_IDX_W-1:0] idx);
		logic signed [CORD_W-1:0] v;
		case (idx)
			5'd0:    v = 34'sh020000000;
			5'd1:    v = 34'sh012E4051E;
			5'd2:    v = 34'sh009FB385B;
			5'd3:    v = 34'sh0051111D4;
			5'd4:    v = 34'sh0028B0D43;
			5'd5:    v = 34'sh00145D7E1;
			5'd6:    v = 34'sh000A2F61E;
			5'd7:    v = 34'sh000517C55;
			5'd8:    v = 34'sh00028BE53;
			5'd9:    v = 34'sh000145F2F;
			5'd10:   v = 34'sh0000A2F98;
			5'd11:   v = 34'sh0000517CC;
			5'd12:   v = 34'sh000028BE6;
			5'd13:   v = 34'sh0000145F3;
			5'd14:   v = 34'sh00000A2FA;
			5'd15:   v = 34'sh00000517D;
			5'd16:   v = 34'sh0000028BE;
			5'd17:   v = 34'sh00000145F;
			5'd18:   v = 34'sh000000A30;
			5'd19:   v = 34'sh000000518;
			5'd20:   v = 34'sh00000028C;
			5'd21:   v = 34'sh000000146;
			5'd22:   v = 34'sh0000000A3;
			5'd23:   v = 34'sh000000051;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* hw/rtl/skdr_if.sv */
// Channel interfaces: wheel sample input, pose output and register write.
`timescale 1ns / 1ps
interface skdr_sample_if;
	logic                valid;
	logic                ready;
	logic signed [31:0]  front_left_count;
	logic signed [31:0]  front_right_count;
	logic signed [31:0]  back_left_count;
	logic signed [31:0]  back_right_count;
	logic [15:0]         yaw_angle;
	logic [19:0]         elapsed_us;
	modport source (output valid, front_left_count, front_right_count, back_left_count,
		back_right_count, yaw_angle, elapsed_us, input ready);
	modport sink (input valid, front_left_count, front_right_count, back_left_count,
		back_right_count, yaw_angle, elapsed_us, output ready);
endinterface

interface skdr_pose_if;
	logic                valid;
	logic                ready;
	logic signed [31:0]  x_position;
	logic signed [31:0]  y_position;
	logic [15:0]         heading;
	logic signed [31:0]  linear_velocity;
	logic signed [31:0]  angular_velocity;
	logic                time_invalid;
	modport source (output valid, x_position, y_position, heading, linear_velocity,
		angular_velocity, time_invalid, input ready);
	modport sink (input valid, x_position, y_position, heading, linear_velocity,
		angular_velocity, time_invalid, output ready);
endinterface

interface skdr_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* hw/rtl/skdr_dp.sv */
// Datapath: deltas, shared multiply-accumulate, CORDIC, dividers and pose registers.
`timescale 1ns / 1ps
module skdr_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  skdr_pkg::dp_cmd_t      cmd,
	output skdr_pkg::dp_status_t   status,
	input  logic                   cfg_we,
	input  logic [31:0]            cfg_data,
	input  logic signed [31:0]     front_left_count,
	input  logic signed [31:0]     front_right_count,
	input  logic signed [31:0]     back_left_count,
	input  logic signed [31:0]     back_right_count,
	input  logic [15:0]            yaw_angle,
	input  logic [19:0]            elapsed_us,
	output logic signed [31:0]     x_position,
	output logic signed [31:0]     y_position,
	output logic [15:0]            heading,
	output logic signed [31:0]     linear_velocity,
	output logic signed [31:0]     angular_velocity,
	output logic                   time_invalid
);
	localparam int CW = skdr_pkg::CORD_W;
	localparam int DX_W = skdr_pkg::ACC_W - skdr_pkg::TRIG_FRAC;
	localparam int PS_W = DX_W + 1;
	localparam logic signed [skdr_pkg::DIST_W-1:0] DV_LIM =
		skdr_pkg::DIST_W'(64'sd8589934592);

	logic [31:0]                         mpc_q;
	logic [31:0]                         last_q [4];
	logic [31:0]                         now_w [4];
	logic signed [31:0]                  d_q [4];
	logic [15:0]                         yaw_q;
	logic [15:0]                         yawdiff_q;
	logic [15:0]                         heading_q;
	logic [19:0]                         elapsed_q;
	logic signed [31:0]                  posx_q;
	logic signed [31:0]                  posy_q;
	logic signed [skdr_pkg::SUM_W-1:0]   sum_q;
	logic signed [skdr_pkg::DTH_W-1:0]   dtheta_q;
	logic signed [skdr_pkg::DIST_W-1:0]  dist_q;
	logic signed [skdr_pkg::ACC_W-1:0]   acc_q;
	logic signed [skdr_pkg::NUMS_W-1:0]  numl_q;
	logic signed [CW-1:0]                cx_q;
	logic signed [CW-1:0]                cy_q;
	logic signed [CW-1:0]                cz_q;
	logic                                flip_q;
	logic [skdr_pkg::NUM_W-1:0]          quo_q [2];
	logic [19:0]                         rem_q [2];
	logic                                neg_q [2];

	logic signed [skdr_pkg::SUM_W-1:0]   sum_w;
	logic                                still_w;
	logic signed [skdr_pkg::DTH_W-1:0]   dtheta_w;
	logic [15:0]                         hplus_w;
	logic signed [CW-1:0]                c_w;
	logic signed [CW-1:0]                s_w;
	logic signed [skdr_pkg::DIST_W-1:0]  dv_w;
	logic signed [skdr_pkg::MA_W-1:0]    mac_a;
	logic signed [skdr_pkg::MB_W-1:0]    mac_b;
	logic [1:0]                          mac_sh;
	logic signed [skdr_pkg::PROD_W-1:0]  prod_w;
	logic signed [skdr_pkg::ACC_W-1:0]   term_w;
	logic signed [skdr_pkg::ACC_W-1:0]   term_sh;
	logic signed [DX_W-1:0]              dxy_w;
	logic signed [skdr_pkg::NUMS_W-1:0]  numa_w;
	logic signed [CW-1:0]                xs_w;
	logic signed [CW-1:0]                ys_w;
	logic signed [CW-1:0]                atan_w;
	logic [20:0]                         trial_w [2];
	logic                                ge_w [2];
	logic [20:0]                         el_w;

	function automatic logic signed [31:0] sat_pos(input logic signed [31:0] p,
		input logic signed [DX_W-1:0] dv);
		logic signed [PS_W-1:0] t;
		t = PS_W'(p) + PS_W'(dv);
		if (t > PS_W'(64'sd2147483647)) begin
			return 32'sh7FFFFFFF;
		end else if (t < PS_W'(-64'sd2147483648)) begin
			return 32'sh80000000;
		end
		return t[31:0];
	endfunction

	function automatic logic signed [31:0] sat_vel(input logic neg,
		input logic [skdr_pkg::NUM_W-1:0] mag);
		if (neg) begin
			if (mag > skdr_pkg::NUM_W'(64'h80000000)) begin
				return 32'sh80000000;
			end
			return -$signed(mag[31:0]);
		end
		if (mag > skdr_pkg::NUM_W'(64'h7FFFFFFF)) begin
			return 32'sh7FFFFFFF;
		end
		return $signed(mag[31:0]);
	endfunction

	assign now_w[0] = front_left_count;
	assign now_w[1] = front_right_count;
	assign now_w[2] = back_left_count;
	assign now_w[3] = back_right_count;

	assign status.time_zero = (elapsed_q == '0);

	always_comb begin
		sum_w = skdr_pkg::SUM_W'(d_q[0]) + skdr_pkg::SUM_W'(d_q[1])
			+ skdr_pkg::SUM_W'(d_q[2]) + skdr_pkg::SUM_W'(d_q[3]);
		still_w = ((33'(d_q[0]) + 33'(d_q[2])) == '0) && ((33'(d_q[1]) + 33'(d_q[3])) == '0);
		dtheta_w = still_w ? '0 : $signed({yawdiff_q[15], yawdiff_q});
		hplus_w = heading_q + 16'h4000;
		c_w = flip_q ? -cx_q : cx_q;
		s_w = flip_q ? -cy_q : cy_q;
		if (dist_q > DV_LIM) begin
			dv_w = DV_LIM;
		end else if (dist_q < -DV_LIM) begin
			dv_w = -DV_LIM;
		end else begin
			dv_w = dist_q;
		end
		xs_w = cx_q >>> cmd.cord_idx;
		ys_w = cy_q >>> cmd.cord_idx;
		atan_w = skdr_pkg::atan_entry(cmd.cord_idx);
		dxy_w = acc_q[skdr_pkg::ACC_W-1:skdr_pkg::TRIG_FRAC];
		numa_w = acc_q[skdr_pkg::NUMS_W-1:0];
		el_w = {1'b0, elapsed_q};
	end

	always_comb begin
		mac_a = skdr_pkg::MA_W'(sum_q);
		mac_b = $signed({5'b0, mpc_q[15:0]});
		mac_sh = 2'd0;
		case (cmd.mac_op)
			skdr_pkg::MAC_SUM_LO: begin
				mac_a = skdr_pkg::MA_W'(sum_q);
				mac_b = $signed({5'b0, mpc_q[15:0]});
			end
			skdr_pkg::MAC_SUM_HI: begin
				mac_a = skdr_pkg::MA_W'(sum_q);
				mac_b = $signed({5'b0, mpc_q[31:16]});
				mac_sh = 2'd1;
			end
			skdr_pkg::MAC_CX0: begin
				mac_a = skdr_pkg::MA_W'(c_w);
				mac_b = $signed({5'b0, dist_q[15:0]});
			end
			skdr_pkg::MAC_CX1: begin
				mac_a = skdr_pkg::MA_W'(c_w);
				mac_b = $signed({5'b0, dist_q[31:16]});
				mac_sh = 2'd1;
			end
			skdr_pkg::MAC_CX2: begin
				mac_a = skdr_pkg::MA_W'(c_w);
				mac_b = $signed({{5{dist_q[47]}}, dist_q[47:32]});
				mac_sh = 2'd2;
			end
			skdr_pkg::MAC_SY0: begin
				mac_a = skdr_pkg::MA_W'(s_w);
				mac_b = $signed({5'b0, dist_q[15:0]});
			end
			skdr_pkg::MAC_SY1: begin
				mac_a = skdr_pkg::MA_W'(s_w);
				mac_b = $signed({5'b0, dist_q[31:16]});
				mac_sh = 2'd1;
			end
			skdr_pkg::MAC_SY2: begin
				mac_a = skdr_pkg::MA_W'(s_w);
				mac_b = $signed({{5{dist_q[47]}}, dist_q[47:32]});
				mac_sh = 2'd2;
			end
			skdr_pkg::MAC_LIN: begin
				mac_a = skdr_pkg::MA_W'(dv_w);
				mac_b = skdr_pkg::VEL_SCALE;
			end
			skdr_pkg::MAC_ANG: begin
				mac_a = skdr_pkg::MA_W'(dtheta_q);
				mac_b = skdr_pkg::VEL_SCALE;
			end
			default: begin
				mac_a = '0;
				mac_b = '0;
			end
		endcase
		prod_w = mac_a * mac_b;
		term_w = skdr_pkg::ACC_W'(prod_w);
		term_sh = term_w <<< {mac_sh, 4'b0};
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			trial_w[l] = {rem_q[l], quo_q[l][skdr_pkg::NUM_W-1]};
			ge_w[l] = (trial_w[l] >= el_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpc_q <= skdr_pkg::MPC_RESET;
			for (int i = 0; i < 4; i++) begin
				last_q[i] <= '0;
			end
			yaw_q <= '0;
			heading_q <= '0;
			posx_q <= '0;
			posy_q <= '0;
		end else begin
			if (cfg_we) begin
				mpc_q <= cfg_data;
			end
			if (cmd.capture) begin
				for (int i = 0; i < 4; i++) begin
					last_q[i] <= now_w[i];
				end
				yaw_q <= yaw_angle;
			end
			if (cmd.sum) begin
				heading_q <= heading_q + 16'(dtheta_w);
			end
			if (cmd.px_latch) begin
				posx_q <= sat_pos(posx_q, dxy_w);
			end
			if (cmd.py_latch) begin
				posy_q <= sat_pos(posy_q, dxy_w);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int i = 0; i < 4; i++) begin
				d_q[i] <= $signed(now_w[i] - last_q[i]);
			end
			yawdiff_q <= yaw_angle - yaw_q;
			elapsed_q <= elapsed_us;
			flip_q <= hplus_w[15];
			cx_q <= skdr_pkg::CORDIC_GAIN;
			cy_q <= '0;
			cz_q <= CW'($signed({heading_q ^ {hplus_w[15], 15'b0}, 16'b0}));
		end
		if (cmd.cord_step) begin
			if (!cz_q[CW-1]) begin
				cx_q <= cx_q - ys_w;
				cy_q <= cy_q + xs_w;
				cz_q <= cz_q - atan_w;
			end else begin
				cx_q <= cx_q + ys_w;
				cy_q <= cy_q - xs_w;
				cz_q <= cz_q + atan_w;
			end
		end
		if (cmd.sum) begin
			sum_q <= sum_w;
			dtheta_q <= dtheta_w;
		end
		if (cmd.mac_en) begin
			acc_q <= cmd.mac_first ? term_sh : acc_q + term_sh;
		end
		if (cmd.dist_latch) begin
			dist_q <= acc_q[skdr_pkg::DIST_FRAC +: skdr_pkg::DIST_W];
		end
		if (cmd.numl_latch) begin
			numl_q <= numa_w;
		end
		if (cmd.div_init) begin
			neg_q[0] <= numl_q[skdr_pkg::NUMS_W-1];
			quo_q[0] <= numl_q[skdr_pkg::NUMS_W-1] ? skdr_pkg::NUM_W'(-numl_q)
				: skdr_pkg::NUM_W'(numl_q);
			rem_q[0] <= '0;
			neg_q[1] <= numa_w[skdr_pkg::NUMS_W-1];
			quo_q[1] <= numa_w[skdr_pkg::NUMS_W-1] ? skdr_pkg::NUM_W'(-numa_w)
				: skdr_pkg::NUM_W'(numa_w);
			rem_q[1] <= '0;
		end
		if (cmd.div_step) begin
			for (int l = 0; l < 2; l++) begin
				rem_q[l] <= ge_w[l] ? 20'(trial_w[l] - el_w) : trial_w[l][19:0];
				quo_q[l] <= {quo_q[l][skdr_pkg::NUM_W-2:0], ge_w[l]};
			end
		end
		if (cmd.load_out) begin
			x_position <= posx_q;
			y_position <= posy_q;
			heading <= heading_q;
			time_invalid <= status.time_zero;
			linear_velocity <= status.time_zero ? '0 : sat_vel(neg_q[0], quo_q[0]);
			angular_velocity <= status.time_zero ? '0 : sat_vel(neg_q[1], quo_q[1]);
		end
	end

endmodule

/* hw/rtl/skdr_ctrl.sv */
// Controller: sequences one sample through the datapath and owns the handshakes.
`timescale 1ns / 1ps
module skdr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  skdr_pkg::dp_status_t status,
	output skdr_pkg::dp_cmd_t    cmd
);
	typedef enum logic [4:0] {
		ST_IDLE, ST_SUM, ST_MD0, ST_MD1, ST_DIST, ST_CORD,
		ST_MX0, ST_MX1, ST_MX2, ST_MY0, ST_MY1, ST_MY2,
		ST_MV, ST_MA, ST_DIVI, ST_DIV, ST_FIN
	} state_t;

	state_t                     state_q;
	logic [skdr_pkg::CNT_W-1:0] cnt_q;
	logic                       out_valid_q;
	logic                       accept;
	logic                       emit;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept = in_valid && in_ready;
	assign emit = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		cmd = '0;
		cmd.mac_op = skdr_pkg::MAC_SUM_LO;
		cmd.cord_idx = cnt_q[skdr_pkg::CORD_IDX_W-1:0];
		cmd.capture = accept;
		cmd.load_out = emit;
		case (state_q)
			ST_SUM: cmd.sum = 1'b1;
			ST_MD0: begin
				cmd.mac_en = 1'b1;
				cmd.mac_first = 1'b1;
				cmd.mac_op = skdr_pkg::MAC_SUM_LO;
			end
			ST_MD1: begin
				cmd.mac_en = 1'b1;
				cmd.mac_op = skdr_pkg::MAC_SUM_HI;
			end
			ST_DIST: cmd.dist_latch = 1'b1;
			ST_CORD: cmd.cord_step = 1'b1;
			ST_MX0: begin
				cmd.mac_en = 1'b1;
				cmd.mac_first = 1'b1;
				cmd.mac_op = skdr_pkg::MAC_CX0;
			end
			ST_MX1: begin
				cmd.mac_en = 1'b1;
				cmd.mac_op = skdr_pkg::MAC_CX1;
			end
			ST_MX2: begin
				cmd.mac_en = 1'b1;
				cmd.mac_op = skdr_pkg::MAC_CX2;
			end
			ST_MY0: begin
				cmd.px_latch = 1'b1;
				cmd.mac_en = 1'b1;
				cmd.mac_first = 1'b1;
				cmd.mac_op = skdr_pkg::MAC_SY0;
			end
			ST_MY1: begin
				cmd.mac_en = 1'b1;
				cmd.mac_op = skdr_pkg::MAC_SY1;
			end
			ST_MY2: begin
				cmd.mac_en = 1'b1;
				cmd.mac_op = skdr_pkg::MAC_SY2;
			end
			ST_MV: begin
				cmd.py_latch = 1'b1;
				cmd.mac_en = 1'b1;
				cmd.mac_first = 1'b1;
				cmd.mac_op = skdr_pkg::MAC_LIN;
			end
			ST_MA: begin
				cmd.numl_latch = 1'b1;
				cmd.mac_en = 1'b1;
				cmd.mac_first = 1'b1;
				cmd.mac_op = skdr_pkg::MAC_ANG;
			end
			ST_DIVI: cmd.div_init = 1'b1;
			ST_DIV: cmd.div_step = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (accept) begin
					state_q <= ST_SUM;
				end
				ST_SUM: state_q <= ST_MD0;
				ST_MD0: state_q <= ST_MD1;
				ST_MD1: state_q <= ST_DIST;
				ST_DIST: begin
					cnt_q <= '0;
					state_q <= ST_CORD;
				end
				ST_CORD: begin
					if (cnt_q == skdr_pkg::CNT_W'(skdr_pkg::CORDIC_STEPS - 1)) begin
						cnt_q <= '0;
						state_q <= ST_MX0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MX0: state_q <= ST_MX1;
				ST_MX1: state_q <= ST_MX2;
				ST_MX2: state_q <= ST_MY0;
				ST_MY0: state_q <= ST_MY1;
				ST_MY1: state_q <= ST_MY2;
				ST_MY2: state_q <= ST_MV;
				ST_MV: state_q <= ST_MA;
				ST_MA: state_q <= ST_DIVI;
				ST_DIVI: begin
					cnt_q <= '0;
					state_q <= status.time_zero ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == skdr_pkg::CNT_W'(skdr_pkg::NUM_W - 1)) begin
						cnt_q <= '0;
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: if (emit) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("sample taken while a beat is in flight");
	a_beat_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("pose beat raised outside finish");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("pending pose beat overwritten");
	a_cord_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CORD) |-> (cnt_q < skdr_pkg::CNT_W'(skdr_pkg::CORDIC_STEPS)))
		else $error("CORDIC step count overrun");
`endif

endmodule

/* hw/rtl/skid_steer_dead_reckoning_unit.sv */
// Top level of the skid-steer dead reckoning unit.
// After a sample beat the controller runs its sum, distance, CORDIC, multiply, divide and
// finish states, skipping divide with zero elapsed time; a new sample waits until finish ends.
// A new sample is taken while the previous pose beat still waits on its output register.
// Reset (arst_n low) clears counts, yaw, position and heading and restores metres_per_count.
`timescale 1ns / 1ps
module skid_steer_dead_reckoning_unit (
	input  logic          clk,
	input  logic          arst_n,
	skdr_sample_if.sink   sample,
	skdr_pose_if.source   pose,
	skdr_cfg_if.sink      cfg
);
	skdr_pkg::dp_cmd_t    cmd;
	skdr_pkg::dp_status_t status;

	assign cfg.ready = 1'b1;

	skdr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (pose.valid),
		.out_ready (pose.ready),
		.status    (status),
		.cmd       (cmd)
	);

	skdr_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg_we            (cfg.valid),
		.cfg_data          (cfg.data),
		.front_left_count  (sample.front_left_count),
		.front_right_count (sample.front_right_count),
		.back_left_count   (sample.back_left_count),
		.back_right_count  (sample.back_right_count),
		.yaw_angle         (sample.yaw_angle),
		.elapsed_us        (sample.elapsed_us),
		.x_position        (pose.x_position),
		.y_position        (pose.y_position),
		.heading           (pose.heading),
		.linear_velocity   (pose.linear_velocity),
		.angular_velocity  (pose.angular_velocity),
		.time_invalid      (pose.time_invalid)
	);

endmodule

/* test/testbench.sv */
// Self-checking testbench for the skid-steer dead reckoning unit: random and directed wheel samples.
`timescale 1ns / 1ps
module testbench;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0]        hdg;
		logic signed [31:0] lin;
		logic signed [31:0] ang;
		logic               tinv;
	} pose_t;

	localparam longint ATAN_TURN [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
		64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
		64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};

	class odometry_board;
		logic [31:0] mpc;
		logic [31:0] prev_cnt [4];
		logic [15:0] prev_yaw;
		longint      px, py;
		logic [15:0] hacc;
		pose_t       pending [$];
		int          errors;

		function new();
			mpc = skdr_pkg::MPC_RESET;
			foreach (prev_cnt[i]) prev_cnt[i] = '0;
			prev_yaw = '0;
			px = 0;
			py = 0;
			hacc = '0;
			errors = 0;
		endfunction

		function longint fshift(longint v, int k);
			return v >>> k;
		endfunction

		function longint mulsh(longint a, longint b, int k);
			longint ah, al, ph;
			ah = fshift(a, 16);
			al = a - ah * 65536;
			ph = fshift(al * b, 16);
			return fshift(ah * b + ph, k - 16);
		endfunction

		function longint sat(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function void trig(logic [15:0] a, output longint c, output longint s);
			logic [31:0] zu;
			logic        flip;
			longint      xc, yc, z, xs, ys;
			zu = {a, 16'h0};
			flip = ((zu + 32'h40000000) & 32'h80000000) != 0;
			if (flip) zu = zu + 32'h80000000;
			z = longint'(signed'(zu));
			xc = 652032874;
			yc = 0;
			for (int i = 0; i < skdr_pkg::CORDIC_STEPS && i < 24; i++) begin
				xs = fshift(xc, i);
				ys = fshift(yc, i);
				if (z >= 0) begin
					xc -= ys; yc += xs; z -= ATAN_TURN[i];
				end else begin
					xc += ys; yc -= xs; z += ATAN_TURN[i];
				end
			end
			c = flip ? -xc : xc;
			s = flip ? -yc : yc;
		endfunction

		function void note_sample(logic [31:0] cnt [4], logic [15:0] yaw, logic [19:0] el);
			longint d[4], sum, travel, dv, c, s, dth, lin, ang;
			logic [15:0] dy;
			pose_t p;
			for (int i = 0; i < 4; i++) begin
				d[i] = longint'(signed'(cnt[i] - prev_cnt[i]));
				prev_cnt[i] = cnt[i];
			end
			sum = d[0] + d[1] + d[2] + d[3];
			travel = mulsh(sum, longint'({32'h0, mpc}), 18);
			dth = 0;
			if (!((d[0] + d[2]) == 0 && (d[1] + d[3]) == 0)) begin
				dy = yaw - prev_yaw;
				dth = longint'(signed'(dy));
			end
			prev_yaw = yaw;
			trig(hacc, c, s);
			px = sat(px + mulsh(travel, c, 30));
			py = sat(py + mulsh(travel, s, 30));
			hacc = hacc + dth[15:0];
			lin = 0;
			ang = 0;
			if (el != 0) begin
				dv = travel;
				if (dv > (64'sd1 <<< 33)) dv = 64'sd1 <<< 33;
				if (dv < -(64'sd1 <<< 33)) dv = -(64'sd1 <<< 33);
				lin = sat(dv * 1000000 / longint'(el));
				ang = sat(dth * 1000000 / longint'(el));
			end
			p.x = px[31:0];
			p.y = py[31:0];
			p.hdg = hacc;
			p.lin = lin[31:0];
			p.ang = ang[31:0];
			p.tinv = (el == 0);
			pending.push_back(p);
		endfunction

		function void check_pose(pose_t got);
			pose_t e;
			if (pending.size() == 0) begin
				$error("unexpected pose beat");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.x !== e.x) begin
				$error("x_position exp %0d got %0d", e.x, got.x); errors++;
			end
			if (got.y !== e.y) begin
				$error("y_position exp %0d got %0d", e.y, got.y); errors++;
			end
			if (got.hdg !== e.hdg) begin
				$error("heading exp %0d got %0d", e.hdg, got.hdg); errors++;
			end
			if (got.lin !== e.lin) begin
				$error("linear_velocity exp %0d got %0d", e.lin, got.lin); errors++;
			end
			if (got.ang !== e.ang) begin
				$error("angular_velocity exp %0d got %0d", e.ang, got.ang); errors++;
			end
			if (got.tinv !== e.tinv) begin
				$error("time_invalid exp %0d got %0d", e.tinv, got.tinv); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	skdr_sample_if sample ();
	skdr_pose_if   pose ();
	skdr_cfg_if    cfg ();
	odometry_board board;
	int            idle_cycles;
	logic          sink_on = 1'b0;

	skid_steer_dead_reckoning_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample.sink),
		.pose   (pose.source),
		.cfg    (cfg.sink)
	);

	always #4 clk = ~clk;

	initial begin
		sample.valid = 1'b0;
		sample.front_left_count = '0;
		sample.front_right_count = '0;
		sample.back_left_count = '0;
		sample.back_right_count = '0;
		sample.yaw_angle = '0;
		sample.elapsed_us = '0;
		pose.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		board = new();
	end

	always @(posedge clk) begin
		if (arst_n && (sample.valid && sample.ready || pose.valid && pose.ready
				|| cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 4000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pose.valid && pose.ready)
			board.check_pose({pose.x_position, pose.y_position, pose.heading,
				pose.linear_velocity, pose.angular_velocity, pose.time_invalid});
	end

	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			w = $urandom_range(0, 18);
			if (!sink_on || $urandom_range(0, 3) == 0) w = 0;
			repeat (w) begin
				@(posedge clk);
				pose.ready <= 1'b0;
			end
			@(posedge clk);
			pose.ready <= 1'b1;
			do @(posedge clk); while (!(pose.valid && pose.ready));
			if (w != 0) pose.ready <= 1'b0;
		end
	end

	task automatic send_sample(logic [31:0] cnt [4], logic [15:0] yaw, logic [19:0] el,
			int gap);
		@(posedge clk);
		repeat (gap) @(posedge clk);
		sample.valid <= 1'b1;
		sample.front_left_count <= cnt[0];
		sample.front_right_count <= cnt[1];
		sample.back_left_count <= cnt[2];
		sample.back_right_count <= cnt[3];
		sample.yaw_angle <= yaw;
		sample.elapsed_us <= el;
		do @(posedge clk); while (!sample.ready);
		board.note_sample(cnt, yaw, el);
		sample.valid <= 1'b0;
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_mpc(logic [31:0] v);
		drain();
		cfg.valid <= 1'b1;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		board.mpc = v;
	endtask

	task automatic random_phase(int n, logic big);
		logic [31:0] cnt [4];
		logic [15:0] yaw;
		logic [19:0] el;
		int          gap;
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < 4; i++) begin
				case ($urandom_range(0, 3))
					0: cnt[i] = $urandom();
					1: cnt[i] = board.prev_cnt[i];
					default: cnt[i] = board.prev_cnt[i] + (big ? $urandom_range(0, 2000000)
						: $urandom_range(0, 400)) - (big ? 1000000 : 200);
				endcase
			end
			if ($urandom_range(0, 7) == 0)
				for (int i = 0; i < 4; i++) cnt[i] = board.prev_cnt[i];
			yaw = $urandom_range(0, 3) == 0 ? 16'($urandom())
				: board.prev_yaw + 16'($urandom_range(0, 2000)) - 16'd1000;
			case ($urandom_range(0, 9))
				0: el = '0;
				1: el = 20'hFFFFF;
				2: el = 20'($urandom_range(1, 8));
				default: el = 20'($urandom_range(20000, 30000))
					^ 20'($urandom_range(0, 1) << 19);
			endcase
			gap = $urandom_range(0, 18);
			if ($urandom_range(0, 2) == 0) gap = 0;
			send_sample(cnt, yaw, el, gap);
		end
	endtask

	initial begin
		logic [31:0] c [4];
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sink_on = 1'b1;
		c = '{32'd100, 32'd100, 32'd100, 32'd100};
		send_sample(c, 16'd0, 20'd25000, 0);
		send_sample(c, 16'd500, 20'd25000, 0);
		c = '{32'd200, 32'd100, 32'd200, 32'd100};
		send_sample(c, 16'd1000, 20'd0, 0);
		c = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
		send_sample(c, 16'hFFFF, 20'hFFFFF, 1);
		c = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000};
		send_sample(c, 16'h7FFF, 20'd1, 0);
		send_sample(c, 16'hFFFF, 20'd1, 0);
		c = '{32'h80000100, 32'h80000000, 32'h80000000, 32'h80000000};
		send_sample(c, 16'h7FFF, 20'd1, 0);
		c = '{32'h0, 32'hFFFFFFFF, 32'h12345678, 32'hEDCBA987};
		send_sample(c, 16'h8000, 20'h80000, 3);
		write_mpc(32'hFFFFFFFF);
		c = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h92345678, 32'h6DCBA987};
		send_sample(c, 16'h4000, 20'd1, 0);
		send_sample(c, 16'h4000, 20'd0, 0);
		write_mpc(32'd0);
		c = '{32'h1, 32'h5, 32'h9, 32'hD};
		send_sample(c, 16'h2000, 20'd7, 0);
		write_mpc(32'd1);
		random_phase(200, 1'b1);
		write_mpc(skdr_pkg::MPC_RESET);
		random_phase(300, 1'b0);
		drain();
		random_phase(50, 1'b1);
		write_mpc(32'hFFFFFFFF);
		random_phase(150, 1'b1);
		write_mpc($urandom());
		random_phase(300, 1'b0);
		drain();
		if (board.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
